[hdl/pic_pkg.sv]
// Shared types, constants and priority functions of the interrupt controller.
package pic_pkg;

  // Width of each per-line request counter
  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned NUM_LINES   = 8;

  // Base vectors loaded by the master strap
  localparam logic [7:0] VEC_MASTER = 8'h08;
  localparam logic [7:0] VEC_SLAVE  = 8'h70;

  // Command-port byte decoding
  localparam int unsigned ICW1_BIT      = 4;
  localparam logic [1:0]  SEL_OCW2      = 2'b00;
  localparam logic [1:0]  SEL_OCW3      = 2'b01;
  localparam int unsigned OCW3_POLL_BIT = 2;
  localparam int unsigned OCW3_RR_BIT   = 1;
  localparam int unsigned OCW3_RIS_BIT  = 0;
  localparam int unsigned OCW3_ESMM_BIT = 6;
  localparam int unsigned OCW3_SMM_BIT  = 5;
  localparam int unsigned ICW4_AEOI_BIT = 1;
  localparam int unsigned ICW4_SFNM_BIT = 4;
  localparam logic [7:0]  VBASE_MASK    = 8'hF8;
  localparam logic [7:0]  POLL_HIT      = 8'h80;

  // ICW sequence steps
  localparam logic [2:0] STEP_ICW2 = 3'd2;
  localparam logic [2:0] STEP_ICW4 = 3'd4;

  typedef enum logic [2:0] {
    FUNC_READ   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_RAISE  = 3'd2,
    FUNC_ACK    = 3'd3,
    FUNC_UNMASK = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    OCW2_EOI_NS  = 3'd1,
    OCW2_EOI_SP  = 3'd3,
    OCW2_ROT_NS  = 3'd5,
    OCW2_SET_PRI = 3'd6,
    OCW2_ROT_SP  = 3'd7
  } ocw2_e;

  typedef struct packed {
    logic [2:0] func;
    logic       port_offset;
    logic [7:0] write_data;
    logic [2:0] irq_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_pending;
    logic [7:0] int_vector;
    logic [7:0] in_service_mask;
  } out_item_t;

  typedef struct packed {
    logic poll;
    logic sfnm;
    logic smm;
    logic rsel;
    logic aeoi;
  } mode_t;

  typedef struct packed {
    logic       found;
    logic [2:0] line;
  } hit_t;

  // Post-item state seen by the result logic
  typedef struct packed {
    logic [7:0] req;
    logic [7:0] mask;
    logic [7:0] isr;
    logic [2:0] lpl;
    logic       smm;
    logic       sfnm;
    logic [7:0] vbase;
  } pic_view_t;

  // Highest-priority set bit; the line after lpl ranks first
  function automatic hit_t top_line(logic [7:0] bits, logic [2:0] lpl);
    hit_t       h;
    logic [2:0] ln;
    h = '0;
    for (int k = 8; k >= 1; k--) begin
      ln = lpl + 3'(k);
      if (bits[ln]) begin
        h.found = 1'b1;
        h.line  = ln;
      end
    end
    return h;
  endfunction

  // Request allowed to interrupt now, under nesting and special mask
  function automatic hit_t pending_line(logic [7:0] req, logic [7:0] mask,
                                        logic [7:0] isr, logic [2:0] lpl,
                                        logic smm, logic sfnm);
    hit_t       hp;
    hit_t       hs;
    logic [2:0] pp;
    logic [2:0] sp;
    hp = top_line(req & ~mask, lpl);
    hs = top_line(isr, lpl);
    pp = hp.line - lpl - 3'd1;
    sp = hs.line - lpl - 3'd1;
    if (hp.found && hs.found && !smm && (pp >= sp) &&
        !(sfnm && (hp.line == hs.line))) begin
      hp.found = 1'b0;
    end
    return hp;
  endfunction

endpackage

[hdl/pic_state.sv]
// Controller registers and the execution of one item on them.
module pic_state import pic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      exec_i,
  input  in_item_t  item_i,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  output pic_view_t view_o,
  output logic [7:0] rd_o
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [7:0]             mask_q, mask_d;
  logic [7:0]             req_q, req_d;
  logic [7:0]             isr_q, isr_d;
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_LINES];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_LINES];
  logic [2:0]             step_q, step_d;
  logic                   active_q, active_d;
  logic [7:0]             vbase_q, vbase_d;
  logic [2:0]             lpl_q, lpl_d;
  mode_t                  flags_q, flags_d;
  logic                   master_q;

  hit_t                   ack_hit;
  hit_t                   isr_hit;
  hit_t                   poll_hit;
  logic [2:0]             cnt_idx;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [7:0]             v;

  // Priority lookups on the current state
  assign ack_hit  = top_line(req_q & ~mask_q, lpl_q);
  assign isr_hit  = top_line(isr_q, lpl_q);
  assign poll_hit = pending_line(req_q, mask_q, isr_q, lpl_q, flags_q.smm, flags_q.sfnm);
  assign v        = item_i.write_data;

  // One counter port: acknowledge uses the chosen line, raise its own line
  assign cnt_idx = (func_e'(item_i.func) == FUNC_ACK) ? ack_hit.line : item_i.irq_line;
  assign cnt_rd  = cnt_q[cnt_idx];

  // Next state of one item
  always_comb begin
    mask_d   = mask_q;
    req_d    = req_q;
    isr_d    = isr_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    active_d = active_q;
    vbase_d  = vbase_q;
    lpl_d    = lpl_q;
    flags_d  = flags_q;
    rd_o     = '0;
    cnt_new  = cnt_rd;
    if (exec_i) begin
      unique case (func_e'(item_i.func))
        FUNC_READ: begin
          if (item_i.port_offset) begin
            rd_o = mask_q;
          end else if (flags_q.poll) begin
            flags_d.poll = 1'b0;
            if (poll_hit.found) begin
              isr_d[poll_hit.line] = 1'b1;
              req_d[poll_hit.line] = 1'b0;
              rd_o = POLL_HIT | {5'd0, poll_hit.line};
            end
          end else begin
            rd_o = flags_q.rsel ? isr_q : req_q;
          end
        end
        FUNC_WRITE: begin
          if (!item_i.port_offset) begin
            priority if (v[ICW1_BIT]) begin
              active_d     = 1'b1;
              step_d       = 3'd1;
              mask_d       = '0;
              isr_d        = '0;
              lpl_d        = 3'd7;
              flags_d.smm  = 1'b0;
              flags_d.poll = 1'b0;
              flags_d.rsel = 1'b0;
            end else if (v[4:3] == SEL_OCW2) begin
              unique case (ocw2_e'(v[7:5]))
                OCW2_EOI_NS: begin
                  if (isr_hit.found) isr_d[isr_hit.line] = 1'b0;
                end
                OCW2_EOI_SP: isr_d[v[2:0]] = 1'b0;
                OCW2_ROT_NS: begin
                  if (isr_hit.found) begin
                    isr_d[isr_hit.line] = 1'b0;
                    lpl_d = isr_hit.line;
                  end
                end
                OCW2_ROT_SP: begin
                  isr_d[v[2:0]] = 1'b0;
                  lpl_d = v[2:0];
                end
                OCW2_SET_PRI: lpl_d = v[2:0];
                default: ;
              endcase
            end else if (v[4:3] == SEL_OCW3) begin
              if (v[OCW3_POLL_BIT]) flags_d.poll = 1'b1;
              if (v[OCW3_RR_BIT])   flags_d.rsel = v[OCW3_RIS_BIT];
              if (v[OCW3_ESMM_BIT]) flags_d.smm  = v[OCW3_SMM_BIT];
            end else begin
            end
          end else if (active_q) begin
            // ICW2..ICW4; the cascade byte is dropped
            step_d = step_q + 3'd1;
            if (step_d == STEP_ICW2) begin
              vbase_d = v & VBASE_MASK;
            end else if (step_d == STEP_ICW4) begin
              flags_d.aeoi = v[ICW4_AEOI_BIT];
              flags_d.sfnm = v[ICW4_SFNM_BIT];
              active_d     = 1'b0;
            end
          end else begin
            mask_d = v;
          end
        end
        FUNC_RAISE: begin
          if (cnt_rd != CNT_MAX) cnt_new = cnt_rd + 1'b1;
          cnt_d[cnt_idx]        = cnt_new;
          req_d[item_i.irq_line] = 1'b1;
        end
        FUNC_ACK: begin
          if (ack_hit.found) begin
            if (cnt_rd != '0) cnt_new = cnt_rd - 1'b1;
            cnt_d[cnt_idx] = cnt_new;
            if (cnt_new == '0) req_d[ack_hit.line] = 1'b0;
            if (!flags_q.aeoi) isr_d[ack_hit.line] = 1'b1;
          end
        end
        FUNC_UNMASK: mask_d[item_i.irq_line] = 1'b0;
        default: ;
      endcase
    end
    // Strap write reloads the default base
    if (cfg_we_i) vbase_d = cfg_data_i ? VEC_MASTER : VEC_SLAVE;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= 8'hFF;
      req_q    <= '0;
      isr_q    <= '0;
      cnt_q    <= '{default: '0};
      step_q   <= '0;
      active_q <= 1'b0;
      vbase_q  <= VEC_MASTER;
      lpl_q    <= '0;
      flags_q  <= '0;
      master_q <= 1'b1;
    end else begin
      mask_q   <= mask_d;
      req_q    <= req_d;
      isr_q    <= isr_d;
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      active_q <= active_d;
      vbase_q  <= vbase_d;
      lpl_q    <= lpl_d;
      flags_q  <= flags_d;
      if (cfg_we_i) master_q <= cfg_data_i;
    end
  end

  // Result sees the state after the item
  assign view_o = '{req: req_d, mask: mask_d, isr: isr_d, lpl: lpl_d,
                    smm: flags_d.smm, sfnm: flags_d.sfnm, vbase: vbase_d};

  // The ICW sequence only runs through its data-port steps
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_q == 3'd1 || step_q == 3'd2 || step_q == 3'd3))
    else $error("init step out of range while initializing");

  // Base vector keeps the low bits of the strap default or ICW2 alignment
  a_vbase_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vbase_q[2:0] == 3'd0)
    else $error("vector base not 8-aligned");

  // Strap value stays consistent with the base after a strap write
  a_strap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (vbase_q == (master_q ? VEC_MASTER : VEC_SLAVE)))
    else $error("strap write did not load base vector");

endmodule

[hdl/pic_resolver.sv]
// Priority resolver: forms one result item from the post-item state.
module pic_resolver import pic_pkg::*; (
  input  pic_view_t  view_i,
  input  logic [7:0] rd_i,
  output out_item_t  result_o
);

  hit_t pend;

  assign pend = pending_line(view_i.req, view_i.mask, view_i.isr, view_i.lpl,
                             view_i.smm, view_i.sfnm);

  // Vector is zero when nothing is pending
  always_comb begin
    result_o.read_data       = rd_i;
    result_o.int_pending     = pend.found;
    result_o.int_vector      = pend.found ? (view_i.vbase + {5'd0, pend.line}) : '0;
    result_o.in_service_mask = view_i.isr;
  end

endmodule

[hdl/priority_interrupt_controller.sv]
// Top level of the eight-line programmable interrupt controller.
// Each item (bus read, bus write, line raise, acknowledge or unmask) sits in
// the input register until it is executed. The edge that executes it also
// loads its result item into the output register. So a result is valid
// once its item has passed the input and output registers, and one item
// per cycle is sustained; the input stalls only while out_stall_i holds a result.
// The whole item is executed by the register update logic between the input
// and output registers, which also sets the clock limit. The strap write
// (cfg_we_i) selects the master or slave default base vector and must be
// issued only while the block is idle.
module priority_interrupt_controller import pic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i
);

  logic       in_vld_q;
  in_item_t   in_q;
  logic       out_vld_q;
  out_item_t  out_q;
  logic       advance;
  pic_view_t  view;
  logic [7:0] rd;
  out_item_t  result;

  // Input item moves on when the output register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  pic_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_i    (advance),
    .item_i    (in_q),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .view_o    (view),
    .rd_o      (rd)
  );

  pic_resolver u_resolver (
    .view_i  (view),
    .rd_i    (rd),
    .result_o(result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_item_i;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Every executed item produces a result next cycle
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("executed item gave no result");

  // No vector without a pending interrupt
  a_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.int_pending) |-> (out_item_o.int_vector == 8'd0))
    else $error("vector set with nothing pending");

endmodule

[test/priority_interrupt_controller_tb.sv]
// Self-checking testbench of the eight-line priority interrupt controller.
module priority_interrupt_controller_tb;
  import pic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // OCW2 codes the block treats as no-ops
  localparam logic [2:0] OCW2_AEOI_CLR  = 3'd0;
  localparam logic [2:0] OCW2_AEOI_SETA = 3'd2;
  localparam logic [2:0] OCW2_AEOI_SETB = 3'd4;
  // Item kinds with no function
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_EVERY = 150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_data_i = 1'b0;

  priority_interrupt_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted controller state
  logic [7:0]             ctl_mask;
  logic [7:0]             ctl_req;
  logic [7:0]             ctl_isr;
  logic [COUNT_WIDTH-1:0] ctl_cnt [NUM_LINES];
  logic [2:0]             icw_step;
  logic                   icw_busy;
  logic [7:0]             ctl_vbase;
  logic [2:0]             ctl_lowest;
  mode_t                  ctl_mode;
  logic                   ctl_master;

  in_item_t  queued_items[$];
  out_item_t expected_results[$];

  int errors = 0;
  int n_acc = 0;
  int recv_count = 0;
  int pending_seen = 0;
  int poll_hits = 0;
  int strap_writes = 0;
  bit drain = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void reset_controller();
    ctl_mask   = 8'hFF;
    ctl_req    = '0;
    ctl_isr    = '0;
    for (int i = 0; i < NUM_LINES; i++) ctl_cnt[i] = '0;
    icw_step   = '0;
    icw_busy   = 1'b0;
    ctl_master = 1'b1;
    ctl_vbase  = VEC_MASTER;
    ctl_lowest = '0;
    ctl_mode   = '0;
  endfunction

  // Highest-ranked set line under the current rotation, -1 if none
  function automatic int rank_pick(logic [7:0] bits);
    logic [2:0] ln;
    for (int k = 1; k <= 8; k++) begin
      ln = ctl_lowest + 3'(k);
      if (bits[ln]) return int'(ln);
    end
    return -1;
  endfunction

  // Line allowed to interrupt now under nesting and special mask
  function automatic int allowed_line();
    int         hp;
    int         hs;
    logic [2:0] pp;
    logic [2:0] sp;
    hp = rank_pick(ctl_req & ~ctl_mask);
    if (hp < 0) return -1;
    hs = rank_pick(ctl_isr);
    if (hs >= 0 && !ctl_mode.smm) begin
      pp = 3'(hp) - ctl_lowest - 3'd1;
      sp = 3'(hs) - ctl_lowest - 3'd1;
      if (pp >= sp && !(ctl_mode.sfnm && hp == hs)) return -1;
    end
    return hp;
  endfunction

  function automatic void apply_write(logic port, logic [7:0] v);
    int hs;
    if (!port) begin
      if (v[ICW1_BIT]) begin
        // ICW1 restarts initialization
        icw_busy      = 1'b1;
        icw_step      = 3'd1;
        ctl_mask      = '0;
        ctl_isr       = '0;
        ctl_lowest    = 3'd7;
        ctl_mode.smm  = 1'b0;
        ctl_mode.poll = 1'b0;
        ctl_mode.rsel = 1'b0;
      end else if (v[4:3] == SEL_OCW2) begin
        case (v[7:5])
          OCW2_EOI_NS: begin
            hs = rank_pick(ctl_isr);
            if (hs >= 0) ctl_isr[hs] = 1'b0;
          end
          OCW2_EOI_SP: ctl_isr[v[2:0]] = 1'b0;
          OCW2_ROT_NS: begin
            hs = rank_pick(ctl_isr);
            if (hs >= 0) begin
              ctl_isr[hs] = 1'b0;
              ctl_lowest  = 3'(hs);
            end
          end
          OCW2_ROT_SP: begin
            ctl_isr[v[2:0]] = 1'b0;
            ctl_lowest      = v[2:0];
          end
          OCW2_SET_PRI: ctl_lowest = v[2:0];
          default: ;
        endcase
      end else if (v[4:3] == SEL_OCW3) begin
        if (v[OCW3_POLL_BIT]) ctl_mode.poll = 1'b1;
        if (v[OCW3_RR_BIT]) ctl_mode.rsel = v[OCW3_RIS_BIT];
        if (v[OCW3_ESMM_BIT]) ctl_mode.smm = v[OCW3_SMM_BIT];
      end
    end else if (icw_busy) begin
      icw_step = icw_step + 3'd1;
      if (icw_step == STEP_ICW2) begin
        ctl_vbase = v & VBASE_MASK;
      end else if (icw_step == STEP_ICW4) begin
        ctl_mode.aeoi = v[ICW4_AEOI_BIT];
        ctl_mode.sfnm = v[ICW4_SFNM_BIT];
        icw_busy      = 1'b0;
      end
    end else begin
      ctl_mask = v;
    end
  endfunction

  function automatic logic [7:0] apply_read(logic port);
    int ln;
    if (port) return ctl_mask;
    if (ctl_mode.poll) begin
      // Poll read takes the pending line into service
      ctl_mode.poll = 1'b0;
      ln = allowed_line();
      if (ln < 0) return '0;
      ctl_isr[ln] = 1'b1;
      ctl_req[ln] = 1'b0;
      poll_hits++;
      return POLL_HIT | 8'(ln);
    end
    return ctl_mode.rsel ? ctl_isr : ctl_req;
  endfunction

  function automatic void apply_ack();
    int ln;
    ln = rank_pick(ctl_req & ~ctl_mask);
    if (ln < 0) return;
    if (ctl_cnt[ln] != '0) ctl_cnt[ln] = ctl_cnt[ln] - 1'b1;
    if (ctl_cnt[ln] == '0) ctl_req[ln] = 1'b0;
    if (!ctl_mode.aeoi) ctl_isr[ln] = 1'b1;
  endfunction

  // Apply one accepted item and queue the result it should produce
  function automatic void step_controller(in_item_t it);
    out_item_t r;
    int        pl;
    r = '0;
    case (it.func)
      FUNC_READ:  r.read_data = apply_read(it.port_offset);
      FUNC_WRITE: apply_write(it.port_offset, it.write_data);
      FUNC_RAISE: begin
        if (ctl_cnt[it.irq_line] != CNT_MAX)
          ctl_cnt[it.irq_line] = ctl_cnt[it.irq_line] + 1'b1;
        ctl_req[it.irq_line] = 1'b1;
      end
      FUNC_ACK:    apply_ack();
      FUNC_UNMASK: ctl_mask[it.irq_line] = 1'b0;
      default: ;
    endcase
    pl = allowed_line();
    if (pl >= 0) begin
      r.int_pending = 1'b1;
      r.int_vector  = ctl_vbase + 8'(pl);
    end
    r.in_service_mask = ctl_isr;
    expected_results.push_back(r);
  endfunction

  function automatic in_item_t mk_item(logic [2:0] f, logic p, logic [7:0] d, logic [2:0] l);
    in_item_t it;
    it.func        = f;
    it.port_offset = p;
    it.write_data  = d;
    it.irq_line    = l;
    return it;
  endfunction

  function automatic logic [7:0] ocw2_byte(logic [2:0] cmd, logic [2:0] ln);
    return {cmd, SEL_OCW2, ln};
  endfunction

  function automatic logic [7:0] ocw3_byte(logic esmm, logic smm, logic poll, logic rr,
                                           logic ris);
    return {1'b0, esmm, smm, SEL_OCW3, poll, rr, ris};
  endfunction

  function automatic void push_cmd(logic [7:0] v);
    queued_items.push_back(mk_item(FUNC_WRITE, 1'b0, v, 3'($urandom)));
  endfunction

  function automatic void push_data(logic [7:0] v);
    queued_items.push_back(mk_item(FUNC_WRITE, 1'b1, v, 3'($urandom)));
  endfunction

  function automatic void push_op(logic [2:0] f, logic [2:0] ln);
    queued_items.push_back(mk_item(f, 1'($urandom), 8'($urandom), ln));
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Command byte biased toward well-formed OCW2 and OCW3 forms
  function automatic logic [7:0] rand_cmd_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ocw2_byte(3'($urandom), 3'($urandom));
      4, 5, 6:    return ocw3_byte(1'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom), 1'($urandom));
      7:          return 8'($urandom) | (8'h1 << ICW1_BIT);
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic void push_init(bit broken);
    push_cmd(8'($urandom) | (8'h1 << ICW1_BIT));
    push_data(8'($urandom));
    push_data(8'($urandom));
    if (!broken) push_data(8'($urandom));
  endfunction

  function automatic void push_rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      push_op(FUNC_RAISE, 3'($urandom));
    else if (r < 50) push_op(FUNC_ACK, 3'($urandom));
    else if (r < 65) push_op(FUNC_READ, 3'($urandom));
    else if (r < 85) push_cmd(rand_cmd_byte());
    else if (r < 93) push_data(($urandom_range(0, 1) != 0) ? 8'($urandom)
                                                           : 8'($urandom & $urandom));
    else if (r < 98) push_op(FUNC_UNMASK, 3'($urandom));
    else             push_op(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 3'($urandom));
  endfunction

  // Mostly initialized sequences with random content, some noise
  function automatic void fill_random(int n);
    int start;
    int r;
    int len;
    start = queued_items.size();
    while (queued_items.size() - start < n) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        push_init($urandom_range(0, 7) == 0);
        len = $urandom_range(10, 40);
        repeat (len) push_rand_op();
      end else if (r < 9) begin
        len = $urandom_range(5, 20);
        repeat (len) push_rand_op();
      end else begin
        len = $urandom_range(3, 10);
        repeat (len) queued_items.push_back(mk_item(3'($urandom), 1'($urandom),
                                                    8'($urandom), 3'($urandom)));
      end
    end
  endfunction

  function automatic void fill_directed();
    queued_items.push_back(mk_item(FUNC_READ, 1'b0, 8'h00, 3'd0));
    queued_items.push_back(mk_item(FUNC_READ, 1'b1, 8'hFF, 3'd7));
    push_op(FUNC_RAISE, 3'd0);
    push_op(FUNC_RAISE, 3'd7);
    push_op(FUNC_UNMASK, 3'd7);
    push_op(FUNC_SPARE_LO, 3'd7);
    push_op(FUNC_SPARE_HI, 3'd0);
    push_op(FUNC_ACK, 3'd0);
    // Full initialization sequence with ICW3 ignored
    push_cmd(8'h13);
    push_data(8'hFF);
    push_data(8'hA5);
    push_data(8'h00);
    push_op(FUNC_RAISE, 3'd3);
    push_op(FUNC_RAISE, 3'd5);
    push_op(FUNC_ACK, 3'd0);
    // Status read of the in-service register
    push_cmd(ocw3_byte(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    queued_items.push_back(mk_item(FUNC_READ, 1'b0, 8'h00, 3'd0));
    // Poll blocked by nesting, then poll under special mask
    push_cmd(ocw3_byte(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    queued_items.push_back(mk_item(FUNC_READ, 1'b0, 8'h00, 3'd0));
    push_cmd(ocw3_byte(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    push_cmd(ocw3_byte(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    queued_items.push_back(mk_item(FUNC_READ, 1'b0, 8'h00, 3'd0));
    // EOI forms, including one with nothing in service
    push_cmd(ocw2_byte(OCW2_EOI_NS, 3'd0));
    push_cmd(ocw2_byte(OCW2_EOI_SP, 3'd3));
    push_cmd(ocw2_byte(OCW2_EOI_NS, 3'd0));
    push_cmd(ocw2_byte(OCW2_SET_PRI, 3'd4));
    push_op(FUNC_ACK, 3'd0);
    push_cmd(ocw2_byte(OCW2_ROT_NS, 3'd0));
    push_cmd(ocw2_byte(OCW2_ROT_SP, 3'd6));
    push_cmd(ocw2_byte(OCW2_AEOI_CLR, 3'd7));
    push_cmd(ocw2_byte(OCW2_AEOI_SETA, 3'd1));
    push_cmd(ocw2_byte(OCW2_AEOI_SETB, 3'd2));
    push_data(8'h5A);
    queued_items.push_back(mk_item(FUNC_READ, 1'b1, 8'h00, 3'd0));
    push_cmd(ocw3_byte(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
  endfunction

  // Drive one line's count past saturation, then ack a few times;
  // a wrapped count would drop the request after the first ack
  function automatic void fill_saturation();
    push_cmd(8'h13);
    push_data(8'h40);
    push_data(8'h00);
    push_data(8'h1 << ICW4_AEOI_BIT);
    repeat (int'(CNT_MAX) + 2) push_op(FUNC_RAISE, 3'd2);
    repeat (8) push_op(FUNC_ACK, 3'd2);
    queued_items.push_back(mk_item(FUNC_READ, 1'b0, 8'h00, 3'd0));
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (!(queued_items.size() == 0 && !in_valid_i && expected_results.size() == 0));
  endtask

  task automatic write_strap(logic v);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    ctl_master = v;
    ctl_vbase  = v ? VEC_MASTER : VEC_SLAVE;
    strap_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stimulus sequencing and end of run
  initial begin
    reset_controller();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_strap(1'b0);
    fill_directed();
    write_strap(1'b1);
    fill_saturation();
    write_strap(1'b0);
    fill_random(50);
    write_strap(1'b1);
    fill_random(50);
    write_strap(1'($urandom));
    fill_random(50);
    write_strap(1'($urandom));
    fill_random(50);
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Run covered %0d items over %0d strap writes: %0d results with an interrupt",
             n_acc, strap_writes, pending_seen);
    $display("pending, %0d poll hits, %0d mismatches.", poll_hits, errors);
    if (errors == 0) begin
      $display("[priority_interrupt_controller] OK");
    end else begin
      $display("[priority_interrupt_controller] ERROR");
    end
    $finish;
  end

  // Driver: accept, predict, then launch the next item after a gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        step_controller(in_item_i);
        n_acc++;
        if (n_acc % DRAIN_EVERY == 0) drain = 1'b1;
      end
      if (drain && recv_count == n_acc) drain = 1'b0;
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!drain && queued_items.size() != 0) begin
          in_item_i  <= queued_items.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
          gap_left = pick_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Monitor: compare each result with the oldest prediction, random stalls
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        recv_count <= recv_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_item_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.int_pending) pending_seen++;
          check_field("read_data", want.read_data, out_item_o.read_data);
          check_field("int_pending", 8'(want.int_pending), 8'(out_item_o.int_pending));
          check_field("int_vector", want.int_vector, out_item_o.int_vector);
          check_field("in_service_mask", want.in_service_mask, out_item_o.in_service_mask);
        end
        if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap(out_calm);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("[priority_interrupt_controller] ERROR");
      $finish;
    end
  end

endmodule
